// ----- rtl/backpressure_periodic_event_scheduler_top_macros.svh -----
// Assertion macros used by the scheduler top level.
`ifndef BACKPRESSURE_PERIODIC_EVENT_SCHEDULER_TOP_MACROS_SVH
`define BACKPRESSURE_PERIODIC_EVENT_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BPES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");
// Next-cycle implication.
`define BPES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");
`else
`define BPES_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bpes_pkg.sv -----
// Types, constants and helper functions of the periodic event scheduler.
package bpes_pkg;

	localparam int NUM_TIMERS = 5;
	localparam int TS_W       = 48;
	localparam int IVL_W      = 16;
	localparam int DEPTH_W    = 5;
	localparam int PCT_W      = 7;
	localparam int IDX_W      = 3;
	localparam int REG_IDX_W  = 3;
	localparam int WIDE_W     = 22;   // base interval times the largest stretch (x32)

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;

	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int DUE_STEP        = 100 / NUM_TIMERS;

	localparam logic [PCT_W-1:0]  LOAD_LOW     = 7'd70;
	localparam logic [PCT_W-1:0]  LOAD_HIGH    = 7'd85;
	localparam logic [PCT_W-1:0]  IDLE_LOW     = 7'd25;
	localparam logic [PCT_W-1:0]  IDLE_CRIT    = 7'd10;
	localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
	localparam logic [WIDE_W-1:0] INTERVAL_MAX = 22'd60000;

	// Register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL4 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_VOICE     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MIN_SLEEP = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SLEEP = 3'd7;

	typedef logic [TS_W-1:0] tstamp_t;

	typedef struct packed {
		logic [NUM_TIMERS-1:0][IVL_W-1:0] interval;
		logic [IVL_W-1:0]                 voice_backoff;
		logic [IVL_W-1:0]                 min_sleep;
		logic [IVL_W-1:0]                 max_sleep;
	} cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		interval:      {16'd5000, 16'd60000, 16'd30000, 16'd10000, 16'd100},
		voice_backoff: 16'd1000,
		min_sleep:     16'd10,
		max_sleep:     16'd1000
	};

	typedef struct packed {
		tstamp_t            now_ms;
		logic [DEPTH_W-1:0] bus_depth;
		logic               link_up;
		logic               voice_busy;
		logic [PCT_W-1:0]   cpu_idle;
	} tick_t;

	// One tick's worth of results handed to the result sequencer
	typedef struct packed {
		logic [NUM_TIMERS-1:0] fire_mask;
		logic [PCT_W-1:0]      load_percent;
		logic [IVL_W-1:0]      next_delay;
	} bundle_t;

	// Base period stretched by backpressure, clamped to 1..60000
	function automatic logic [IVL_W-1:0] stretch_interval(
		input logic             low_prio,
		input logic [IVL_W-1:0] base,
		input logic [IVL_W-1:0] backoff,
		input logic             link_up,
		input logic             voice_busy,
		input logic [PCT_W-1:0] cpu_idle,
		input logic [PCT_W-1:0] load
	);
		logic [WIDE_W-1:0] v;
		v = {{(WIDE_W-IVL_W){1'b0}}, base};
		if (!link_up) begin
			v = {v[WIDE_W-2:0], 1'b0};
		end
		if (load >= LOAD_HIGH) begin
			v = low_prio ? {v[WIDE_W-3:0], 2'b00} : {v[WIDE_W-2:0], 1'b0};
		end else if (load >= LOAD_LOW && low_prio) begin
			v = {v[WIDE_W-2:0], 1'b0};
		end
		if (cpu_idle < IDLE_CRIT) begin
			v = low_prio ? {v[WIDE_W-3:0], 2'b00} : {v[WIDE_W-2:0], 1'b0};
		end else if (cpu_idle < IDLE_LOW) begin
			v = low_prio ? v + {v[WIDE_W-2:0], 1'b0} : {v[WIDE_W-2:0], 1'b0};
		end
		if (voice_busy) begin
			v = {{(WIDE_W-IVL_W){1'b0}}, backoff};
		end
		if (v == '0) begin
			v = WIDE_W'(1);
		end else if (v > INTERVAL_MAX) begin
			v = INTERVAL_MAX;
		end
		return v[IVL_W-1:0];
	endfunction

	// Index of the lowest set bit of a fire mask
	function automatic logic [IDX_W-1:0] lowest_index(input logic [NUM_TIMERS-1:0] mask);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/bpes_timer_bank.sv -----
// Next-due registers of the five timers, due detection and rescheduling.
module bpes_timer_bank import bpes_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tick_t                             tick,
	input  logic [PCT_W-1:0]                  load,
	input  cfg_regs_t                         cfg,
	input  logic                              update,
	output logic [NUM_TIMERS-1:0]             due,
	output tstamp_t [NUM_TIMERS-1:0]          next_due
);

	tstamp_t [NUM_TIMERS-1:0] next_due_q;
	tstamp_t [NUM_TIMERS-1:0] resched;

	always_comb begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			due[i]     = (next_due_q[i] == '0) || (tick.now_ms >= next_due_q[i]);
			resched[i] = tick.now_ms + TS_W'(stretch_interval(i == 0, cfg.interval[i],
				cfg.voice_backoff, tick.link_up, tick.voice_busy, tick.cpu_idle, load));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_due_q <= '0;
		end else if (update) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (due[i]) begin
					next_due_q[i] <= resched[i];
				end
			end
		end
	end

	assign next_due = next_due_q;

endmodule

// ----- rtl/bpes_delay_calc.sv -----
// Sleep delay until the next timer is due, clamped to the sleep limits.
module bpes_delay_calc import bpes_pkg::*; (
	input  tstamp_t                  now_ms,
	input  tstamp_t [NUM_TIMERS-1:0] next_due,
	input  logic [IVL_W-1:0]         min_sleep,
	input  logic [IVL_W-1:0]         max_sleep,
	output logic [IVL_W-1:0]         next_delay
);

	logic [NUM_TIMERS-1:0]            pending;
	logic [NUM_TIMERS-1:0][IVL_W-1:0] gap;
	logic [IVL_W-1:0]                 best;
	tstamp_t                          diff;

	always_comb begin
		best = max_sleep;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			pending[i] = (next_due[i] == '0) || (next_due[i] <= now_ms);
			diff       = next_due[i] - now_ms;
			// saturate: anything past 16 bits never beats the running minimum
			gap[i]     = (|diff[TS_W-1:IVL_W]) ? '1 : diff[IVL_W-1:0];
			if (gap[i] < best) begin
				best = gap[i];
			end
		end
		if (|pending) begin
			next_delay = min_sleep;
		end else begin
			next_delay = best;
			if (next_delay < min_sleep) begin
				next_delay = min_sleep;
			end
			if (next_delay > max_sleep) begin
				next_delay = max_sleep;
			end
		end
	end

endmodule

// ----- rtl/bpes_emitter.sv -----
// Result register: plays out fire items in timer order, then the summary.
module bpes_emitter import bpes_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_en,
	input  bundle_t                bundle,
	output logic                   can_load,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic                  busy_q;
	logic [NUM_TIMERS-1:0] mask_q;
	logic [PCT_W-1:0]      load_q;
	logic [IVL_W-1:0]      delay_q;
	logic                  summary;
	logic                  take;
	logic [IDX_W-1:0]      idx;

	assign summary  = (mask_q == '0);
	assign take     = busy_q && m_tready;
	assign can_load = !busy_q || (take && summary);
	assign idx      = lowest_index(mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
		end else if (load_en) begin
			busy_q <= 1'b1;
			mask_q <= bundle.fire_mask;
		end else if (take) begin
			if (summary) begin
				busy_q <= 1'b0;
			end else begin
				mask_q <= mask_q & (mask_q - NUM_TIMERS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			load_q  <= bundle.load_percent;
			delay_q <= bundle.next_delay;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = summary;
	assign m_tlast  = summary;
	assign m_tdata  = {(OUT_TDATA_W-IVL_W-PCT_W-IDX_W)'(0),
		summary ? delay_q : '0, load_q, summary ? '0 : idx};

endmodule

// ----- rtl/backpressure_periodic_event_scheduler_top.sv -----
// Top level of the backpressure periodic event scheduler.
// Five periodic timers driven by ticks. A tick is accepted on the s_ stream
// into an input register (s1); while it is held there, the queue load is
// computed from the bus depth and the number of due timers, and when s1
// advances every due timer fires, its new due time (now plus the stretched
// interval) is written into the timer bank and the fire mask is registered
// (s2). The following stage derives the clamped sleep delay from the updated
// due times and hands the whole tick to the result register, which emits one
// fire item per due timer in index order and then a summary item (tuser = 1,
// tlast = 1), the tick passing s1 and s2 on its way there. The pipeline takes
// one tick per cycle while the result channel keeps up; that channel sets the
// sustained rate, moving one item per cycle while m_tready is high, and a tick
// with k due timers gives it k + 1 items. Registers are written on the cfg_
// port and take effect at once, also on ticks still in the pipeline, so write
// them only while no tick is in flight; cfg_ready is always high.
`include "backpressure_periodic_event_scheduler_top_macros.svh"
module backpressure_periodic_event_scheduler_top import bpes_pkg::*; #(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// tick stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [47:0] now_ms, [52:48] bus_depth, [53] link up, [54] voice_busy,
	// [61:55] cpu_idle, [63:62] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] timer_index, [9:3] load_percent, [25:10] next_delay, [31:26] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// [0] kind: 0 timer fired, 1 end-of-tick summary
	output logic                   m_tuser,
	output logic                   m_tlast,
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [IVL_W-1:0]       cfg_data
);

	cfg_regs_t cfg_q;

	logic                  valid_s1;
	tick_t                 tick_s1;
	logic                  valid_s2;
	tstamp_t               now_s2;
	logic [NUM_TIMERS-1:0] mask_s2;
	logic [PCT_W-1:0]      load_s2;

	logic                     adv_s1;
	logic                     adv_s2;
	logic                     em_ready;
	logic [NUM_TIMERS-1:0]    due;
	tstamp_t [NUM_TIMERS-1:0] next_due;
	logic [IDX_W-1:0]         due_num;
	logic [PCT_W-1:0]         due_pct;
	logic [PCT_W-1:0]         depth_pct;
	logic [PCT_W-1:0]         load;
	logic [IVL_W-1:0]         next_delay;
	bundle_t                  bundle;

	// ---------------- configuration registers ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INTERVAL0: cfg_q.interval[0]   <= cfg_data;
				REG_INTERVAL1: cfg_q.interval[1]   <= cfg_data;
				REG_INTERVAL2: cfg_q.interval[2]   <= cfg_data;
				REG_INTERVAL3: cfg_q.interval[3]   <= cfg_data;
				REG_INTERVAL4: cfg_q.interval[4]   <= cfg_data;
				REG_VOICE:     cfg_q.voice_backoff <= cfg_data;
				REG_MIN_SLEEP: cfg_q.min_sleep     <= cfg_data;
				REG_MAX_SLEEP: cfg_q.max_sleep     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// s2 only moves on when the result register can take a new tick; s1 only
	// moves (and commits the timer update) when s2 is free, so the timer bank
	// always reflects exactly the tick held in s2 while it waits.
	assign adv_s2   = valid_s2 && em_ready;
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_s2);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload: unpack the tick on accept, hold stage 2 until it advances
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.now_ms     <= s_tdata[TS_W-1:0];
			tick_s1.bus_depth  <= s_tdata[TS_W+DEPTH_W-1:TS_W];
			tick_s1.link_up    <= s_tdata[TS_W+DEPTH_W];
			tick_s1.voice_busy <= s_tdata[TS_W+DEPTH_W+1];
			tick_s1.cpu_idle   <= s_tdata[TS_W+DEPTH_W+PCT_W+1:TS_W+DEPTH_W+2];
		end
		if (adv_s1) begin
			now_s2  <= tick_s1.now_ms;
			mask_s2 <= due;
			load_s2 <= load;
		end
	end

	// ---------------- queue load ----------------
	// Bus load per queue depth, saturated; built at elaboration.
	logic [PCT_W-1:0] depth_pct_tab [2**DEPTH_W];

	for (genvar d = 0; d < 2**DEPTH_W; d++) begin : g_depth_pct
		localparam int DepthPct = (d * 100) / QUEUE_SLOTS;
		assign depth_pct_tab[d] = (DepthPct > int'(PCT_MAX)) ? PCT_MAX : PCT_W'(DepthPct);
	end

	always_comb begin
		due_num = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			due_num = due_num + IDX_W'(due[i]);
		end
	end

	assign due_pct   = PCT_W'(due_num) * PCT_W'(DUE_STEP);
	assign depth_pct = depth_pct_tab[tick_s1.bus_depth];
	assign load      = (depth_pct > due_pct) ? depth_pct : due_pct;

	// ---------------- timers ----------------
	bpes_timer_bank u_timer_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_s1),
		.load     (load),
		.cfg      (cfg_q),
		.update   (adv_s1),
		.due      (due),
		.next_due (next_due)
	);

	bpes_delay_calc u_delay_calc (
		.now_ms     (now_s2),
		.next_due   (next_due),
		.min_sleep  (cfg_q.min_sleep),
		.max_sleep  (cfg_q.max_sleep),
		.next_delay (next_delay)
	);

	assign bundle = '{fire_mask: mask_s2, load_percent: load_s2, next_delay: next_delay};

	// ---------------- results ----------------
	bpes_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (adv_s2),
		.bundle   (bundle),
		.can_load (em_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// ---------------- checks ----------------
	// A fire item is always followed by more results of the same tick.
	`BPES_ASSERT_NEXT(a_fire_then_more, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)
	// Fire items of one tick come in rising timer order.
	`BPES_ASSERT_NEXT(a_fire_order, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tlast || (m_tdata[2:0] > $past(m_tdata[2:0])))
	// All results of one tick report the same load.
	`BPES_ASSERT_NEXT(a_same_load, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tdata[9:3] == $past(m_tdata[9:3]))
	// A stalled stage 2 never lets the timer bank change under it.
	`BPES_ASSERT_IMP(a_no_update_on_stall, clk, arst_n, valid_s2 && !adv_s2, !adv_s1)

endmodule
